// ===== hw/rtl/fakc_pkg.sv =====
// ============================================================================
// Fire alarm keypad controller package
// Shared types, register map codes, key codes and reset values.
// ============================================================================
package fakc_pkg;

    localparam int CODE_MAX_DEF = 8;

    localparam int TEMP_W  = 10;
    localparam int SMOKE_W = 10;
    localparam int KEY_W   = 8;
    localparam int SCALE_W = 7;
    localparam int CNT_W   = 4;
    localparam int CODE_W  = 64;
    localparam int LEN_W   = 4;

    // Register map, indexed by paddr[5:3].
    localparam logic [2:0] REG_HEAT_HIGH   = 3'd0;
    localparam logic [2:0] REG_HEAT_LOW    = 3'd1;
    localparam logic [2:0] REG_SMOKE_LIMIT = 3'd2;
    localparam logic [2:0] REG_UNLOCK_CODE = 3'd3;
    localparam logic [2:0] REG_CODE_LENGTH = 3'd4;

    localparam logic [TEMP_W-1:0]  HEAT_HIGH_RST   = 10'd50;
    localparam logic [TEMP_W-1:0]  HEAT_LOW_RST    = 10'd40;
    localparam logic [SCALE_W-1:0] SMOKE_LIMIT_RST = 7'd50;
    localparam logic [CODE_W-1:0]  UNLOCK_CODE_RST = 64'd228509037105;
    localparam logic [LEN_W-1:0]   CODE_LENGTH_RST = 4'd5;

    localparam logic [KEY_W-1:0] KEY_CLEAR  = 8'h63;
    localparam logic [KEY_W-1:0] KEY_SUBMIT = 8'h3D;

    // x / 10 == (x * 205) >> 11 for every 10-bit x.
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    typedef enum logic [1:0] {
        MODE_FINE = 2'd0,
        MODE_HEAT = 2'd1,
        MODE_FIRE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        UNLOCK_NONE = 2'd0,
        UNLOCK_OK   = 2'd1,
        UNLOCK_BAD  = 2'd2
    } t_unlock;

    typedef struct packed {
        logic [TEMP_W-1:0]  heat_high;
        logic [TEMP_W-1:0]  heat_low;
        logic [SCALE_W-1:0] smoke_limit;
        logic [CODE_W-1:0]  unlock_code;
        logic [LEN_W-1:0]   code_length;
    } t_cfg;

    typedef struct packed {
        logic [TEMP_W-1:0]  temperature;
        logic [SMOKE_W-1:0] smoke_raw;
        logic               key_valid;
        logic [KEY_W-1:0]   key_code;
    } t_item;

    typedef struct packed {
        t_mode              alarm_state;
        logic               fine_led;
        logic               heat_led;
        logic               red_led;
        logic               fan_on;
        t_unlock            unlock_result;
        logic [CNT_W-1:0]   keys_entered;
        logic [SCALE_W-1:0] smoke_scaled;
    } t_result;

endpackage

// ===== hw/rtl/fakc_cfg.sv =====
// ============================================================================
// Configuration registers
// APB-style register file holding thresholds and the unlock code.
// ============================================================================
module fakc_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output fakc_pkg::t_cfg      o_cfg
);

    fakc_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heat_high   <= fakc_pkg::HEAT_HIGH_RST;
            r_cfg.heat_low    <= fakc_pkg::HEAT_LOW_RST;
            r_cfg.smoke_limit <= fakc_pkg::SMOKE_LIMIT_RST;
            r_cfg.unlock_code <= fakc_pkg::UNLOCK_CODE_RST;
            r_cfg.code_length <= fakc_pkg::CODE_LENGTH_RST;
        end else if (wr_en) begin
            case (reg_idx)
                fakc_pkg::REG_HEAT_HIGH:   r_cfg.heat_high   <= pwdata[9:0];
                fakc_pkg::REG_HEAT_LOW:    r_cfg.heat_low    <= pwdata[9:0];
                fakc_pkg::REG_SMOKE_LIMIT: r_cfg.smoke_limit <= pwdata[6:0];
                fakc_pkg::REG_UNLOCK_CODE: r_cfg.unlock_code <= pwdata;
                fakc_pkg::REG_CODE_LENGTH: r_cfg.code_length <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fakc_pkg::REG_HEAT_HIGH:   prdata = 64'(r_cfg.heat_high);
            fakc_pkg::REG_HEAT_LOW:    prdata = 64'(r_cfg.heat_low);
            fakc_pkg::REG_SMOKE_LIMIT: prdata = 64'(r_cfg.smoke_limit);
            fakc_pkg::REG_UNLOCK_CODE: prdata = r_cfg.unlock_code;
            fakc_pkg::REG_CODE_LENGTH: prdata = 64'(r_cfg.code_length);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/fakc_core.sv =====
// ============================================================================
// Alarm core
// Mode register, code entry buffer and the single-pass update for one item.
// ============================================================================
module fakc_core #(
    parameter int CODE_MAX = fakc_pkg::CODE_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  fakc_pkg::t_item     i_item,
    input  fakc_pkg::t_cfg      i_cfg,
    output fakc_pkg::t_result   o_result
);

    localparam int CW = $clog2(CODE_MAX + 1);
    localparam int IW = (CODE_MAX > 1) ? $clog2(CODE_MAX) : 1;

    fakc_pkg::t_mode   r_mode;
    fakc_pkg::t_mode   n_mode;
    fakc_pkg::t_mode   mode_temp;
    fakc_pkg::t_mode   mode_shown;
    fakc_pkg::t_unlock unlock;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [7:0]        r_buf [CODE_MAX];
    logic              buf_we;
    logic [17:0]       smoke_prod;
    logic [6:0]        smoke_div;
    logic [6:0]        scaled;
    logic              match;

    assign smoke_prod = i_item.smoke_raw * fakc_pkg::DIV10_MUL;
    assign smoke_div  = smoke_prod[17:fakc_pkg::DIV10_SHIFT];

    // Only the characters typed since the last clear or submit take part in the compare.
    always_comb begin
        match = (fakc_pkg::LEN_W'(r_count) == i_cfg.code_length) &&
                (i_cfg.code_length <= fakc_pkg::LEN_W'(CODE_MAX));
        for (int i = 0; i < CODE_MAX; i++) begin
            if ((CW'(i) < r_count) && (r_buf[i] != i_cfg.unlock_code[8*i +: 8])) begin
                match = 1'b0;
            end
        end
    end

    // Next state.
    always_comb begin
        mode_temp = r_mode;
        if (r_mode != fakc_pkg::MODE_FIRE) begin
            if (i_item.temperature >= i_cfg.heat_high) begin
                mode_temp = fakc_pkg::MODE_HEAT;
            end else if (i_item.temperature < i_cfg.heat_low) begin
                mode_temp = fakc_pkg::MODE_FINE;
            end
        end

        scaled     = '0;
        mode_shown = mode_temp;
        if (mode_temp != fakc_pkg::MODE_FINE) begin
            scaled = smoke_div;
            if (smoke_div >= i_cfg.smoke_limit) begin
                mode_shown = fakc_pkg::MODE_FIRE;
            end
        end

        n_mode  = mode_shown;
        n_count = r_count;
        unlock  = fakc_pkg::UNLOCK_NONE;
        buf_we  = 1'b0;
        if (mode_shown == fakc_pkg::MODE_FIRE && i_item.key_valid) begin
            if (i_item.key_code == fakc_pkg::KEY_CLEAR) begin
                n_count = '0;
            end else if (i_item.key_code == fakc_pkg::KEY_SUBMIT) begin
                n_count = '0;
                if (match) begin
                    unlock = fakc_pkg::UNLOCK_OK;
                    n_mode = fakc_pkg::MODE_FINE;
                end else begin
                    unlock = fakc_pkg::UNLOCK_BAD;
                end
            end else if (r_count < CW'(CODE_MAX)) begin
                buf_we  = 1'b1;
                n_count = CW'(r_count + CW'(1));
            end
        end
    end

    // Result decode.
    always_comb begin
        o_result.alarm_state   = mode_shown;
        o_result.fine_led      = (mode_shown == fakc_pkg::MODE_FINE);
        o_result.heat_led      = (mode_shown == fakc_pkg::MODE_HEAT);
        o_result.red_led       = (mode_shown == fakc_pkg::MODE_FIRE);
        o_result.fan_on        = (mode_shown == fakc_pkg::MODE_FIRE);
        o_result.unlock_result = unlock;
        o_result.keys_entered  = fakc_pkg::CNT_W'(n_count);
        o_result.smoke_scaled  = scaled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= fakc_pkg::MODE_FINE;
            r_count <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && buf_we) begin
            r_buf[r_count[IW-1:0]] <= i_item.key_code;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CODE_MAX))
        else $error("entry count beyond buffer size");

    a_count_only_in_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != fakc_pkg::MODE_FIRE |-> r_count == '0)
        else $error("characters held outside the fire state");

    a_unlock_to_fine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && unlock == fakc_pkg::UNLOCK_OK |=> r_mode == fakc_pkg::MODE_FINE)
        else $error("accepted code did not return to fine");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_mode) && $stable(r_count))
        else $error("state changed without an item");
`endif

endmodule

// ===== hw/rtl/fire_alarm_keypad_controller.sv =====
// ============================================================================
// Fire alarm keypad controller
// Temperature hysteresis, smoke latch and keypad unlock, one item per tick.
// ============================================================================
// Usage:
//   The slave stream carries one tick per item: tdata holds temperature,
//   smoke reading and key code, tuser flags a valid key press. The master
//   stream returns one result item per input item, in order.
//   An accepted item sits in an input register; once the result register
//   is empty or draining, it is evaluated against the alarm state and the
//   result register is loaded, and the master side offers it from there.
//   Throughput is one item per cycle: the whole update is a single pass
//   through the core, and o_s_axis_tready stays high as long as the
//   result register drains or is empty.
//   When the receiver stalls, the result is held, the pending input item
//   waits in the input register, and tready drops only then.
//   Reset brings the state to fine with no characters entered and loads the
//   register defaults; the APB port should be written only while no item
//   is in flight.
// ============================================================================
module fire_alarm_keypad_controller #(
    parameter int CODE_MAX = fakc_pkg::CODE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [9:0] temperature, [19:10] smoke_raw, [27:20] key_code, [31:28] zero
    input  logic [31:0] i_s_axis_tdata,
    // [0] key_valid
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] alarm_state, [2] fine_led, [3] heat_led, [4] red_led,
    // [5] fan_on, [7:6] unlock_result, [11:8] keys_entered,
    // [18:12] smoke_scaled, [23:19] zero
    output logic [23:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    fakc_pkg::t_cfg    cfg;
    fakc_pkg::t_item   r_in;
    fakc_pkg::t_result r_out;
    fakc_pkg::t_result result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              step;
    logic              in_take;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    fakc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fakc_core #(
        .CODE_MAX (CODE_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.temperature <= i_s_axis_tdata[9:0];
            r_in.smoke_raw   <= i_s_axis_tdata[19:10];
            r_in.key_code    <= i_s_axis_tdata[27:20];
            r_in.key_valid   <= i_s_axis_tuser;
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.smoke_scaled, r_out.keys_entered,
                              r_out.unlock_result, r_out.fan_on, r_out.red_led,
                              r_out.heat_led, r_out.fine_led, r_out.alarm_state};

endmodule

// ===== sim/tb_fire_alarm_keypad_controller.sv =====
// ============================================================================
// Fire alarm keypad controller testbench
// Drives tick items into the slave stream and checks every result item
// against a cycle-free model of the alarm state, smoke latch and keypad
// entry. The register set is changed between phases while the block is
// idle. Both streams idle at random, and the result side is held off once
// for a long stretch so that the block stalls its input.
// ============================================================================
module tb_fire_alarm_keypad_controller;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 1000;
    localparam int PHASES       = 8;

    // Tracks the alarm state and keypad entry and keeps the result items
    // still owed by the block, oldest first.
    class alarm_predictor;
        logic [fakc_pkg::TEMP_W-1:0]  heat_high;
        logic [fakc_pkg::TEMP_W-1:0]  heat_low;
        logic [fakc_pkg::SCALE_W-1:0] smoke_limit;
        logic [fakc_pkg::CODE_W-1:0]  unlock_code;
        logic [fakc_pkg::LEN_W-1:0]   code_length;
        fakc_pkg::t_mode              mode;
        logic [fakc_pkg::KEY_W-1:0]   entered[fakc_pkg::CODE_MAX_DEF];
        int unsigned                  n_entered;
        fakc_pkg::t_result            due_outputs[$];
        int                           errors;

        function new();
            heat_high   = fakc_pkg::HEAT_HIGH_RST;
            heat_low    = fakc_pkg::HEAT_LOW_RST;
            smoke_limit = fakc_pkg::SMOKE_LIMIT_RST;
            unlock_code = fakc_pkg::UNLOCK_CODE_RST;
            code_length = fakc_pkg::CODE_LENGTH_RST;
            mode        = fakc_pkg::MODE_FINE;
            n_entered   = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                fakc_pkg::REG_HEAT_HIGH:   heat_high   = value[fakc_pkg::TEMP_W-1:0];
                fakc_pkg::REG_HEAT_LOW:    heat_low    = value[fakc_pkg::TEMP_W-1:0];
                fakc_pkg::REG_SMOKE_LIMIT: smoke_limit = value[fakc_pkg::SCALE_W-1:0];
                fakc_pkg::REG_UNLOCK_CODE: unlock_code = value;
                fakc_pkg::REG_CODE_LENGTH: code_length = value[fakc_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function bit code_ok();
            if (n_entered != code_length || code_length > fakc_pkg::CODE_MAX_DEF)
                return 1'b0;
            for (int i = 0; i < n_entered; i++)
                if (entered[i] != unlock_code[8*i +: 8])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_tick(fakc_pkg::t_item it);
            logic [fakc_pkg::SCALE_W-1:0] scaled;
            fakc_pkg::t_unlock            verdict;
            fakc_pkg::t_mode              shown;
            fakc_pkg::t_result            r;
            scaled  = '0;
            verdict = fakc_pkg::UNLOCK_NONE;
            if (mode != fakc_pkg::MODE_FIRE) begin
                if (it.temperature >= heat_high)
                    mode = fakc_pkg::MODE_HEAT;
                else if (it.temperature < heat_low)
                    mode = fakc_pkg::MODE_FINE;
            end
            if (mode != fakc_pkg::MODE_FINE) begin
                scaled = fakc_pkg::SCALE_W'(int'(it.smoke_raw) / 10);
                if (scaled >= smoke_limit)
                    mode = fakc_pkg::MODE_FIRE;
            end
            // The reported state is the one before any unlock on this tick.
            shown = mode;
            if (mode == fakc_pkg::MODE_FIRE && it.key_valid) begin
                if (it.key_code == fakc_pkg::KEY_CLEAR) begin
                    n_entered = 0;
                end else if (it.key_code == fakc_pkg::KEY_SUBMIT) begin
                    if (code_ok()) begin
                        verdict = fakc_pkg::UNLOCK_OK;
                        mode    = fakc_pkg::MODE_FINE;
                    end else begin
                        verdict = fakc_pkg::UNLOCK_BAD;
                    end
                    n_entered = 0;
                end else if (n_entered < fakc_pkg::CODE_MAX_DEF) begin
                    entered[n_entered] = it.key_code;
                    n_entered++;
                end
            end
            r.alarm_state   = shown;
            r.fine_led      = (shown == fakc_pkg::MODE_FINE);
            r.heat_led      = (shown == fakc_pkg::MODE_HEAT);
            r.red_led       = (shown == fakc_pkg::MODE_FIRE);
            r.fan_on        = (shown == fakc_pkg::MODE_FIRE);
            r.unlock_result = verdict;
            r.keys_entered  = fakc_pkg::CNT_W'(n_entered);
            r.smoke_scaled  = scaled;
            due_outputs.push_back(r);
        endfunction

        function void cmp(string fld, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, want, got);
                errors++;
            end
        endfunction

        function void check_output(logic [23:0] d);
            fakc_pkg::t_result want;
            if (due_outputs.size() == 0) begin
                $display("%0t: result item with none expected: expected nothing, actual %h",
                         $time, d);
                errors++;
                return;
            end
            want = due_outputs.pop_front();
            cmp("alarm_state",   want.alarm_state,   d[1:0]);
            cmp("fine_led",      want.fine_led,      d[2]);
            cmp("heat_led",      want.heat_led,      d[3]);
            cmp("red_led",       want.red_led,       d[4]);
            cmp("fan_on",        want.fan_on,        d[5]);
            cmp("unlock_result", want.unlock_result, d[7:6]);
            cmp("keys_entered",  want.keys_entered,  d[11:8]);
            cmp("smoke_scaled",  want.smoke_scaled,  d[18:12]);
            cmp("padding",       0,                  d[23:19]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic        s_user;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    alarm_predictor predictor;
    int             cycles;
    int             sent;
    bit             quiet;
    bit             hold_req;

    fire_alarm_keypad_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            predictor.check_output(m_data);
    end

    // Result side: random stalls, none while quiet, and one long hold-off.
    initial begin
        m_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 15);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high.
    task automatic send_tick(input logic [9:0] temp, input logic [9:0] smoke,
                             input logic kv, input logic [7:0] key);
        fakc_pkg::t_item it;
        it.temperature = temp;
        it.smoke_raw   = smoke;
        it.key_valid   = kv;
        it.key_code    = key;
        if (!quiet && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0, key, smoke, temp};
        s_user  <= kv;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predictor.note_tick(it);
        sent++;
        @(negedge i_clk);
    endtask

    // Drops psel after the access and waits before returning so that writes never overlap.
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        predictor.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Lowers tvalid and waits until every result item has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (predictor.due_outputs.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_regs(input logic [9:0] hh, input logic [9:0] hl,
                             input logic [6:0] lim, input logic [63:0] code,
                             input logic [3:0] len);
        reg_write(fakc_pkg::REG_HEAT_HIGH, 64'(hh));
        reg_write(fakc_pkg::REG_HEAT_LOW, 64'(hl));
        reg_write(fakc_pkg::REG_SMOKE_LIMIT, 64'(lim));
        reg_write(fakc_pkg::REG_UNLOCK_CODE, code);
        reg_write(fakc_pkg::REG_CODE_LENGTH, 64'(len));
    endtask

    function automatic logic [9:0] any10();
        return 10'($urandom_range(0, 1023));
    endfunction

    // Latch fire if needed, type a code (mostly the stored one) and submit.
    task automatic code_burst();
        int          n;
        int          lim10;
        bit          right;
        logic [7:0]  k;
        lim10 = 10 * predictor.smoke_limit;
        if (predictor.mode != fakc_pkg::MODE_FIRE)
            send_tick(10'($urandom_range(1023, predictor.heat_high)),
                      lim10 > 1023 ? any10() : 10'($urandom_range(1023, lim10)),
                      1'b0, 8'h00);
        right = ($urandom_range(99) < 70);
        if (right)
            n = (predictor.code_length > fakc_pkg::CODE_MAX_DEF)
                ? fakc_pkg::CODE_MAX_DEF : predictor.code_length;
        else
            n = $urandom_range(0, fakc_pkg::CODE_MAX_DEF + 1);
        if ($urandom_range(99) < 10)
            send_tick(any10(), any10(), 1'b1, fakc_pkg::KEY_CLEAR);
        for (int i = 0; i < n; i++) begin
            k = right ? predictor.unlock_code[8*i +: 8] : 8'($urandom_range(0, 255));
            send_tick(any10(), any10(), 1'b1, k);
        end
        send_tick(any10(), any10(), 1'b1, fakc_pkg::KEY_SUBMIT);
    endtask

    task automatic noise_tick();
        logic [9:0] temp;
        logic [7:0] key;
        int         sel;
        sel = $urandom_range(99);
        if (sel < 25)
            temp = 10'($urandom_range(predictor.heat_high + 3, predictor.heat_high - 3));
        else if (sel < 50)
            temp = 10'($urandom_range(predictor.heat_low + 3, predictor.heat_low - 3));
        else
            temp = any10();
        sel = $urandom_range(99);
        if (sel < 20)
            key = fakc_pkg::KEY_CLEAR;
        else if (sel < 40)
            key = fakc_pkg::KEY_SUBMIT;
        else
            key = 8'($urandom_range(0, 255));
        send_tick(temp, any10(), 1'($urandom_range(0, 1)), key);
    endtask

    initial begin
        int target;
        predictor = new();
        cycles    = 0;
        sent      = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        i_rst_n   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        s_user    = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed ticks on the reset register set; the stored code is "12345".
        send_tick(10'd0, 10'd0, 1'b1, 8'hFF);        // key while fine is ignored
        send_tick(10'd50, 10'd499, 1'b0, 8'h00);     // heat, smoke just below limit
        send_tick(10'd45, 10'd1023, 1'b1, 8'h31);    // fire latches, key counts
        send_tick(10'd0, 10'd0, 1'b1, 8'h32);        // temperature ignored in fire
        send_tick(10'd1023, 10'd0, 1'b1, 8'h33);
        send_tick(10'd0, 10'd0, 1'b1, 8'h34);
        send_tick(10'd0, 10'd0, 1'b1, 8'h35);
        send_tick(10'd0, 10'd0, 1'b1, fakc_pkg::KEY_SUBMIT);   // match, back to fine
        send_tick(10'd39, 10'd1023, 1'b0, 8'h00);
        send_tick(10'd1023, 10'd500, 1'b1, fakc_pkg::KEY_CLEAR);
        send_tick(10'd0, 10'd0, 1'b1, fakc_pkg::KEY_SUBMIT);   // empty entry is wrong
        // Nine characters; the last one does not fit the buffer.
        for (int i = 0; i < 9; i++)
            send_tick(10'd1023, 10'd1023, 1'b1, i[0] ? 8'h00 : 8'hFF);
        send_tick(10'd0, 10'd0, 1'b1, fakc_pkg::KEY_SUBMIT);
        send_tick(10'd0, 10'd0, 1'b0, fakc_pkg::KEY_SUBMIT);   // no key press
        send_tick(10'd0, 10'd0, 1'b1, fakc_pkg::KEY_CLEAR);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                1: load_regs(10'd0, 10'd0, 7'd0, {$urandom, $urandom}, 4'd1);
                2: load_regs(10'd1023, 10'd1023, 7'd102, {$urandom, $urandom}, 4'd8);
                3: load_regs(10'd100, 10'd600, 7'd127, {$urandom, $urandom}, 4'd0);
                4: load_regs(10'd1023, 10'd0, 7'd1, '1, 4'd15);
                5, 6: load_regs(any10(), any10(), 7'($urandom_range(0, 127)),
                                {$urandom, $urandom}, 4'($urandom_range(0, 15)));
                7: load_regs(fakc_pkg::HEAT_HIGH_RST, fakc_pkg::HEAT_LOW_RST,
                             fakc_pkg::SMOKE_LIMIT_RST, fakc_pkg::UNLOCK_CODE_RST,
                             fakc_pkg::CODE_LENGTH_RST);
                default: ;
            endcase
            quiet = (ph == 2);
            if (ph == 4)
                hold_req = 1'b1;
            target = sent + ITEM_TARGET / PHASES;
            while (sent < target) begin
                if ($urandom_range(99) < 65)
                    code_burst();
                else
                    noise_tick();
            end
        end
        quiet = 1'b0;
        drain();
        repeat (10) @(posedge i_clk);
        if (predictor.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
